@@ hw/rtl/fbpot_pkg.sv @@
// Shared widths, codes and reset values for the flash block program-order tracker.
`timescale 1ns / 1ps
`default_nettype none

package fbpot_pkg;

  // Field widths of the command and result beats.
  localparam int ACTION_W  = 2;
  localparam int TARGET_W  = 22;
  localparam int COUNT_W   = 11;
  localparam int STATUS_W  = 3;
  localparam int PLACE_W   = 12;

  // Geometry register widths.
  localparam int PIB_W     = 11;
  localparam int BPP_W     = 13;
  localparam int PID_W     = 5;
  localparam int DIC_W     = 3;
  localparam int TOTAL_W   = 23;
  localparam int PD_W      = PID_W + DIC_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Shared divider operand widths.
  localparam int DIV_W     = 23;
  localparam int DIVISOR_W = 13;

  // Command codes.
  localparam logic [ACTION_W-1:0] ACT_SEED    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PROGRAM = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_ERASE   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ORDER  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ERASED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_SEED   = 3'd4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_BLOCK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_PLANE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANES_IN_DIE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIES_IN_CHANNEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_TOTAL      = 3'd4;

  // Register reset values.
  localparam logic [PIB_W-1:0]   RST_PAGES_IN_BLOCK  = 11'd256;
  localparam logic [BPP_W-1:0]   RST_BLOCKS_IN_PLANE = 13'd64;
  localparam logic [PID_W-1:0]   RST_PLANES_IN_DIE   = 5'd4;
  localparam logic [DIC_W-1:0]   RST_DIES_IN_CHANNEL = 3'd1;
  localparam logic [TOTAL_W-1:0] RST_PAGE_TOTAL      = 23'd65536;

endpackage

`default_nettype wire

@@ hw/rtl/fbpot_divider.sv @@
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fbpot_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [fbpot_pkg::DIV_W-1:0]     dividend,
  input  wire logic [fbpot_pkg::DIVISOR_W-1:0] divisor,
  output logic                                done,
  output logic [fbpot_pkg::DIV_W-1:0]          quotient,
  output logic [fbpot_pkg::DIVISOR_W-1:0]      remainder
);
  import fbpot_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0]     quot;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [CNT_W-1:0]     count;
  logic                 busy;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // The partial remainder stays below the divisor, so the trial value
  // needs only one extra bit.
  assign trial = {rem, quot[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIV_W-2:0], fits};
      rem  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient  = quot;
  assign remainder = rem;

endmodule

`default_nettype wire

@@ hw/rtl/flash_block_program_order_tracker.sv @@
// Top level of the flash block program-order tracker.
//
// The tracker keeps one next-page counter per flash block in an internal
// memory of MAX_BLOCKS words and checks that pages are programmed in order.
// Each command beat (seed, program, read check or erase) yields exactly one
// result beat with a status, a block-restart flag and the bank and channel
// that hold the addressed page or block. All arithmetic runs through one
// shared restoring divider that produces one quotient bit per cycle: the
// first division finds the block and page (or the block limit for seed and
// erase), the second the bank, and the third the channel, dividing by the
// product of planes per die and dies per channel. A command's result beat
// is presented once the three divisions have run, each followed by a step
// in which its quotient is picked up, then S_UPDATE updates the counter and
// S_FINISH loads the output register. A command that fails the range check
// is presented right after the first division. Only one command is in
// flight, and in_stall stays high until its result has been moved into the
// output register, which may still hold an earlier result waiting on
// out_stall; the next command is therefore accepted only after that. After
// reset the block sweeps the counter memory to zero, one entry per cycle,
// so it takes no command until the sweep is done; configuration writes are
// taken during that sweep and should otherwise only be issued while no
// command is outstanding. A geometry register written as zero behaves as
// one.
`timescale 1ns / 1ps
`default_nettype none

module flash_block_program_order_tracker #(
  parameter int MAX_BLOCKS = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port.
  input  wire logic                             cfg_write,
  input  wire logic [fbpot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fbpot_pkg::CFG_DATA_W-1:0] cfg_data,
  // Command channel.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [fbpot_pkg::ACTION_W-1:0]   action,
  input  wire logic [fbpot_pkg::TARGET_W-1:0]   target,
  input  wire logic [fbpot_pkg::COUNT_W-1:0]    seed_count,
  // Result channel.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [fbpot_pkg::STATUS_W-1:0]        status,
  output logic                                  block_restart,
  output logic [fbpot_pkg::PLACE_W-1:0]         bank_index,
  output logic [fbpot_pkg::PLACE_W-1:0]         channel_index
);
  import fbpot_pkg::*;

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [DIV_W-1:0] BLOCK_LIMIT = DIV_W'(MAX_BLOCKS);

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_DIV_BLOCK = 7'b0000100,
    S_DIV_BANK  = 7'b0001000,
    S_DIV_CHAN  = 7'b0010000,
    S_UPDATE    = 7'b0100000,
    S_FINISH    = 7'b1000000
  } state_t;

  state_t state;

  // Geometry registers.
  logic [PIB_W-1:0]   pages_in_block;
  logic [BPP_W-1:0]   blocks_in_plane;
  logic [PID_W-1:0]   planes_in_die;
  logic [DIC_W-1:0]   dies_in_channel;
  logic [TOTAL_W-1:0] page_total;

  logic [PIB_W-1:0]   pib_nz;
  logic [BPP_W-1:0]   bpp_nz;
  logic [PID_W-1:0]   pid_nz;
  logic [DIC_W-1:0]   dic_nz;
  logic [TOTAL_W-1:0] total_nz;
  logic [PD_W-1:0]    pd_nz;

  // Command being worked on.
  logic [ACTION_W-1:0] act_q;
  logic [TARGET_W-1:0] target_q;
  logic [COUNT_W-1:0]  seed_q;
  logic [AW-1:0]       blk;
  logic [COUNT_W-1:0]  page_q;
  logic                traffic_started;
  logic [AW-1:0]       clr_addr;

  // Result waiting for the output register.
  logic [STATUS_W-1:0] res_status;
  logic                res_restart;
  logic [PLACE_W-1:0]  bank_q;
  logic [PLACE_W-1:0]  chan_q;
  logic                out_load;

  // Shared divider.
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quotient;
  logic [DIVISOR_W-1:0] div_remainder;

  // Counter memory.
  logic [COUNT_W-1:0] next_page_table [MAX_BLOCKS];
  logic [COUNT_W-1:0] rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [COUNT_W-1:0] mem_wd;

  logic               is_block_cmd;
  logic [DIV_W-1:0]   blk_full;
  logic               blk_fail;
  logic               upd_we;
  logic [COUNT_W-1:0] upd_data;
  logic [STATUS_W-1:0] upd_status;
  logic               upd_restart;

  assign pib_nz   = (pages_in_block == '0) ? PIB_W'(1) : pages_in_block;
  assign bpp_nz   = (blocks_in_plane == '0) ? BPP_W'(1) : blocks_in_plane;
  assign pid_nz   = (planes_in_die == '0) ? PID_W'(1) : planes_in_die;
  assign dic_nz   = (dies_in_channel == '0) ? DIC_W'(1) : dies_in_channel;
  assign total_nz = (page_total == '0) ? TOTAL_W'(1) : page_total;

  // Nested floor divisions by planes and by dies equal one division by
  // their product.
  assign pd_nz = {{DIC_W{1'b0}}, pid_nz} * {{PID_W{1'b0}}, dic_nz};

  assign in_stall = (state != S_IDLE);

  // The finished result moves into the output register once that register
  // is empty or its beat is taken in the same cycle.
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  assign is_block_cmd = (act_q == ACT_SEED) || (act_q == ACT_ERASE);

  // Seed and erase name the block directly and the first division gives the
  // number of blocks in the device; program and read take the block from
  // the first quotient.
  always_comb begin
    if (is_block_cmd) begin
      blk_full = {1'b0, target_q};
      blk_fail = ({1'b0, target_q} >= div_quotient) ||
                 ({1'b0, target_q} >= BLOCK_LIMIT);
    end else begin
      blk_full = div_quotient;
      blk_fail = ({1'b0, target_q} >= total_nz) ||
                 (div_quotient >= BLOCK_LIMIT);
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = blk_full;
    div_divisor  = {{(DIVISOR_W-PIB_W){1'b0}}, pib_nz};
    unique case (state)
      S_IDLE: begin
        div_start = in_valid;
        if ((action == ACT_SEED) || (action == ACT_ERASE)) begin
          div_dividend = total_nz;
        end else begin
          div_dividend = {1'b0, target};
        end
      end
      S_DIV_BLOCK: begin
        div_start   = div_done && !blk_fail;
        div_divisor = bpp_nz;
      end
      S_DIV_BANK: begin
        div_start    = div_done;
        div_dividend = div_quotient;
        div_divisor  = {{(DIVISOR_W-PD_W){1'b0}}, pd_nz};
      end
      default: begin
      end
    endcase
  end

  fbpot_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Counter update once the block's entry has been read.
  always_comb begin
    upd_we      = 1'b0;
    upd_data    = '0;
    upd_status  = STAT_OK;
    upd_restart = 1'b0;
    unique case (act_q)
      ACT_SEED: begin
        if (traffic_started || (seed_q > pib_nz)) begin
          upd_status = STAT_SEED;
        end else if (seed_q != '0) begin
          upd_we   = 1'b1;
          upd_data = seed_q;
        end
      end
      ACT_PROGRAM: begin
        if ((page_q != '0) && (page_q != rd_q)) begin
          upd_status = STAT_ORDER;
        end else begin
          upd_we      = 1'b1;
          upd_data    = page_q + COUNT_W'(1);
          upd_restart = (page_q == '0);
        end
      end
      ACT_READ: begin
        if (page_q >= rd_q) begin
          upd_status = STAT_ERASED;
        end
      end
      ACT_ERASE: begin
        upd_we = 1'b1;
      end
    endcase
  end

  assign mem_we = (state == S_CLEAR) || ((state == S_UPDATE) && upd_we);
  assign mem_wa = (state == S_CLEAR) ? clr_addr : blk;
  assign mem_wd = (state == S_CLEAR) ? '0 : upd_data;

  // The read address holds from the first division until the update, so the
  // registered read data is settled long before it is used.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_page_table[mem_wa] <= mem_wd;
    end
    rd_q <= next_page_table[blk];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_block  <= RST_PAGES_IN_BLOCK;
      blocks_in_plane <= RST_BLOCKS_IN_PLANE;
      planes_in_die   <= RST_PLANES_IN_DIE;
      dies_in_channel <= RST_DIES_IN_CHANNEL;
      page_total      <= RST_PAGE_TOTAL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PAGES_IN_BLOCK:  pages_in_block  <= cfg_data[PIB_W-1:0];
        REG_BLOCKS_IN_PLANE: blocks_in_plane <= cfg_data[BPP_W-1:0];
        REG_PLANES_IN_DIE:   planes_in_die   <= cfg_data[PID_W-1:0];
        REG_DIES_IN_CHANNEL: dies_in_channel <= cfg_data[DIC_W-1:0];
        REG_PAGE_TOTAL:      page_total      <= cfg_data[TOTAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      traffic_started <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIV_BLOCK;
          end
        end
        S_DIV_BLOCK: begin
          if (div_done) begin
            state <= blk_fail ? S_FINISH : S_DIV_BANK;
          end
        end
        S_DIV_BANK: begin
          if (div_done) begin
            state <= S_DIV_CHAN;
          end
        end
        S_DIV_CHAN: begin
          if (div_done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (act_q == ACT_PROGRAM) begin
            traffic_started <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command and result payload.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          act_q    <= action;
          target_q <= target;
          seed_q   <= seed_count;
        end
      end
      S_DIV_BLOCK: begin
        if (div_done) begin
          blk         <= blk_full[AW-1:0];
          page_q      <= div_remainder[COUNT_W-1:0];
          res_status  <= STAT_RANGE;
          res_restart <= 1'b0;
          bank_q      <= '0;
          chan_q      <= '0;
        end
      end
      S_DIV_BANK: begin
        if (div_done) begin
          bank_q <= div_quotient[PLACE_W-1:0];
        end
      end
      S_DIV_CHAN: begin
        if (div_done) begin
          chan_q <= div_quotient[PLACE_W-1:0];
        end
      end
      S_UPDATE: begin
        res_status  <= upd_status;
        res_restart <= upd_restart;
      end
      S_FINISH: begin
        if (out_load) begin
          status        <= res_status;
          block_restart <= res_restart;
          bank_index    <= bank_q;
          channel_index <= chan_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/fbpot_checker.sv @@
// Port-level checker for the flash block program-order tracker, and its bind.
`timescale 1ns / 1ps
`default_nettype none

module fbpot_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [fbpot_pkg::STATUS_W-1:0] status,
  input wire logic                           block_restart,
  input wire logic [fbpot_pkg::PLACE_W-1:0]  bank_index,
  input wire logic [fbpot_pkg::PLACE_W-1:0]  channel_index
);
  import fbpot_pkg::*;

  // One command at a time: the beat after an accepted command is stalled.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted while another was in flight");

  // A range failure reports no placement and no restart.
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_RANGE) |->
      !block_restart && (bank_index == '0) && (channel_index == '0))
    else $error("range failure carries placement or restart");

  // Only an accepted program of page zero restarts a block.
  a_restart_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_restart |-> (status == STAT_OK))
    else $error("block restart flagged on a failed command");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(status) && $stable(block_restart) &&
      $stable(bank_index) && $stable(channel_index))
    else $error("stalled result beat changed");

endmodule

bind flash_block_program_order_tracker fbpot_checker u_fbpot_checker (.*);

`default_nettype wire

@@ tb/flash_block_program_order_tracker_checker.sv @@
// Result checker for the flash block program-order tracker: predicts and compares results.
`timescale 1ns / 1ps

module flash_block_program_order_tracker_checker
  import fbpot_pkg::*;
#(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [ACTION_W-1:0]   action,
  input  logic [TARGET_W-1:0]   target,
  input  logic [COUNT_W-1:0]    seed_count,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [STATUS_W-1:0]   status,
  input  logic                  block_restart,
  input  logic [PLACE_W-1:0]    bank_index,
  input  logic [PLACE_W-1:0]    channel_index,
  output int                    mismatches,
  output int                    pending
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                restart;
    logic [PLACE_W-1:0]  bank;
    logic [PLACE_W-1:0]  channel;
  } verdict_t;

  logic [PIB_W-1:0]   pages_in_block;
  logic [BPP_W-1:0]   blocks_in_plane;
  logic [PID_W-1:0]   planes_in_die;
  logic [DIC_W-1:0]   dies_in_channel;
  logic [TOTAL_W-1:0] page_total;

  logic [COUNT_W-1:0] page_counter [MAX_BLOCKS];
  logic               programmed;
  verdict_t           awaited [$];
  int                 errors = 0;

  // A geometry register written as zero divides and compares as one.
  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic verdict_t place_block(int unsigned blk);
    verdict_t    v;
    int unsigned bank;
    v         = '0;
    v.status  = STAT_OK;
    bank      = blk / at_least_one(blocks_in_plane);
    v.bank    = PLACE_W'(bank);
    v.channel = PLACE_W'(bank / at_least_one(planes_in_die) /
                         at_least_one(dies_in_channel));
    return v;
  endfunction

  // Applies one command to the block counters and returns the result it must produce.
  function automatic verdict_t track_command(logic [ACTION_W-1:0] op,
                                             logic [TARGET_W-1:0] tgt,
                                             logic [COUNT_W-1:0]  cnt);
    verdict_t    v;
    int unsigned per_block, limit, blk, page;
    per_block = at_least_one(pages_in_block);
    limit     = at_least_one(page_total);
    v         = '0;
    v.status  = STAT_OK;
    if (op == ACT_SEED || op == ACT_ERASE) begin
      blk = tgt;
      if (blk >= limit / per_block || blk >= MAX_BLOCKS) begin
        v.status = STAT_RANGE;
        return v;
      end
      v = place_block(blk);
      if (op == ACT_ERASE) begin
        page_counter[blk] = '0;
      end else if (programmed || cnt > per_block) begin
        v.status = STAT_SEED;
      end else if (cnt != 0) begin
        page_counter[blk] = cnt;
      end
      return v;
    end
    if (tgt >= limit) begin
      v.status = STAT_RANGE;
      return v;
    end
    blk = tgt / per_block;
    if (blk >= MAX_BLOCKS) begin
      v.status = STAT_RANGE;
      return v;
    end
    page = tgt % per_block;
    v    = place_block(blk);
    if (op == ACT_PROGRAM) begin
      programmed = 1'b1;
      if (page != 0 && page != page_counter[blk]) begin
        v.status = STAT_ORDER;
        return v;
      end
      page_counter[blk] = COUNT_W'(page + 1);
      v.restart         = (page == 0);
    end else if (page >= page_counter[blk]) begin
      v.status = STAT_ERASED;
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t got, want;
    if (rst) begin
      pages_in_block  = RST_PAGES_IN_BLOCK;
      blocks_in_plane = RST_BLOCKS_IN_PLANE;
      planes_in_die   = RST_PLANES_IN_DIE;
      dies_in_channel = RST_DIES_IN_CHANNEL;
      page_total      = RST_PAGE_TOTAL;
      for (int b = 0; b < MAX_BLOCKS; b++) page_counter[b] = '0;
      programmed = 1'b0;
      awaited.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PAGES_IN_BLOCK:  pages_in_block  = cfg_data[PIB_W-1:0];
          REG_BLOCKS_IN_PLANE: blocks_in_plane = cfg_data[BPP_W-1:0];
          REG_PLANES_IN_DIE:   planes_in_die   = cfg_data[PID_W-1:0];
          REG_DIES_IN_CHANNEL: dies_in_channel = cfg_data[DIC_W-1:0];
          REG_PAGE_TOTAL:      page_total      = cfg_data[TOTAL_W-1:0];
          default: ;
        endcase
      end
      // The result beat always belongs to an earlier command, so pop before queuing.
      if (out_valid && !out_stall) begin
        got = {status, block_restart, bank_index, channel_index};
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: result beat with none expected: status %0d restart %0b ",
                      "bank %0d channel %0d"},
                     $time, got.status, got.restart, got.bank, got.channel);
        end else begin
          want = awaited.pop_front();
          if (got.status !== want.status || got.restart !== want.restart ||
              got.bank !== want.bank || got.channel !== want.channel) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: result mismatch: expected status %0d restart %0b bank %0d ",
                        "channel %0d, got status %0d restart %0b bank %0d channel %0d"},
                       $time, want.status, want.restart, want.bank, want.channel,
                       got.status, got.restart, got.bank, got.channel);
          end
        end
      end
      if (in_valid && !in_stall)
        awaited.insert(awaited.size(), track_command(action, target, seed_count));
    end
    pending    <= awaited.size();
    mismatches <= errors;
  end

endmodule

@@ tb/flash_block_program_order_tracker_test.sv @@
// Testbench top for the flash block program-order tracker: stimulus, reset and verdict.
`timescale 1ns / 1ps

module flash_block_program_order_tracker_test;
  import fbpot_pkg::*;

  localparam int MAX_BLOCKS = 4096;
  // Nothing moves for the whole counter sweep after reset and for the long
  // receiver hold-off, so the quiet-cycle limit sits well above both.
  localparam int WATCHDOG_LIMIT = 20000;
  // Extra wait after the last result, longer than a command's path from acceptance to result.
  localparam int SETTLE_CYCLES  = 120;
  // The receiver holds off once for this many cycles after HOLD_AFTER command beats.
  localparam int LONG_HOLD      = 700;
  localparam int HOLD_AFTER     = 400;
  // An index past the last register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [ACTION_W-1:0]   action     = ACT_SEED;
  logic [TARGET_W-1:0]   target     = '0;
  logic [COUNT_W-1:0]    seed_count = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic                  block_restart;
  logic [PLACE_W-1:0]    bank_index;
  logic [PLACE_W-1:0]    channel_index;

  int mismatches;
  int pending;
  int commands_sent = 0;
  int burst_left    = 0;
  int quiet_cycles  = 0;

  // Geometry as the stimulus sees it, already with zero read as one. geo_blocks is the
  // number of blocks that a page address can reach inside the device and the table.
  int unsigned geo_pages  = 256;
  int unsigned geo_total  = 65536;
  int unsigned geo_blocks = 256;
  // Block and page that the current in-order programming run is at.
  int unsigned seq_block  = 0;
  int unsigned seq_page   = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  flash_block_program_order_tracker #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .target       (target),
    .seed_count   (seed_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .block_restart(block_restart),
    .bank_index   (bank_index),
    .channel_index(channel_index)
  );

  flash_block_program_order_tracker_checker #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .target       (target),
    .seed_count   (seed_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .block_restart(block_restart),
    .bank_index   (bank_index),
    .channel_index(channel_index),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // Offers one command beat and returns after the edge that accepts it. The sender works in
  // bursts: while a burst lasts, valid stays high and the next beat follows at once;
  // at the end of a burst valid drops for a gap that is mostly short, sometimes long
  // enough to leave the block idle across all of its division steps.
  task automatic issue(input logic [ACTION_W-1:0] act, input logic [TARGET_W-1:0] tgt,
                       input logic [COUNT_W-1:0] cnt);
    in_valid   <= 1'b1;
    action     <= act;
    target     <= tgt;
    seed_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    commands_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 100)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Drops valid and waits until every result has come back, plus the block's latency,
  // so that the register writes that follow land on an idle block.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes all five geometry registers plus the unmapped index, then works out which
  // addresses the in-order runs can use under the new geometry. Only the bits that a
  // register holds count, so data with stray upper bits is reduced here the same way.
  task automatic configure(input logic [CFG_DATA_W-1:0] pib, input logic [CFG_DATA_W-1:0] bpp,
                           input logic [CFG_DATA_W-1:0] pid, input logic [CFG_DATA_W-1:0] dic,
                           input logic [CFG_DATA_W-1:0] total);
    write_register(REG_PAGES_IN_BLOCK, pib);
    write_register(REG_BLOCKS_IN_PLANE, bpp);
    write_register(REG_PLANES_IN_DIE, pid);
    write_register(REG_UNMAPPED, CFG_DATA_W'($urandom));
    write_register(REG_DIES_IN_CHANNEL, dic);
    write_register(REG_PAGE_TOTAL, total);
    cfg_write <= 1'b0;
    geo_pages  = (pib[PIB_W-1:0] == 0) ? 1 : pib[PIB_W-1:0];
    geo_total  = (total[TOTAL_W-1:0] == 0) ? 1 : total[TOTAL_W-1:0];
    geo_blocks = geo_total / geo_pages;
    if (geo_blocks > MAX_BLOCKS) geo_blocks = MAX_BLOCKS;
    if (geo_blocks > (1 << TARGET_W) / geo_pages) geo_blocks = (1 << TARGET_W) / geo_pages;
    // With no whole block in the device the runs still go on in block 0; seeds, erases and
    // pages at or past the page total come back out of range.
    if (geo_blocks == 0) geo_blocks = 1;
    seq_block = 0;
    seq_page  = 0;
  endtask

  // One random command. Most beats continue an in-order programming run through a
  // block, with reads of its pages and now and then an erase, so that the counters
  // climb deep into the blocks. The rest are programs out of order, addresses on the
  // edges of the geometry and fully random beats.
  task automatic random_command();
    int unsigned roll, page, tgt;
    roll = $urandom_range(0, 99);
    if (seq_page >= geo_pages || $urandom_range(0, 19) == 0) begin
      seq_block = $urandom_range(0, geo_blocks - 1);
      seq_page  = 0;
    end
    if (roll < 55) begin
      page = seq_page;
      if ($urandom_range(0, 19) == 0) begin
        // Broken run: a random page, which is a write-order error unless it falls on the
        // counter or is page zero and restarts the block.
        page = $urandom_range(0, geo_pages - 1);
        if (page == 0) seq_page = 1;
      end else begin
        seq_page++;
      end
      issue(ACT_PROGRAM, TARGET_W'(seq_block * geo_pages + page), COUNT_W'($urandom));
    end else if (roll < 72) begin
      page = $urandom_range(0, geo_pages - 1);
      issue(ACT_READ, TARGET_W'(seq_block * geo_pages + page), COUNT_W'($urandom));
    end else if (roll < 76) begin
      seq_page = 0;
      issue(ACT_ERASE, TARGET_W'(seq_block), COUNT_W'($urandom));
    end else if (roll < 88) begin
      case ($urandom_range(0, 6))
        0:       tgt = geo_total - 1;
        1:       tgt = geo_total;
        2:       tgt = geo_total / geo_pages - 1;
        3:       tgt = geo_total / geo_pages;
        4:       tgt = MAX_BLOCKS - 1 + $urandom_range(0, 1);
        5:       tgt = MAX_BLOCKS * geo_pages - $urandom_range(0, 1);
        default: tgt = (1 << TARGET_W) - 1;
      endcase
      issue(ACTION_W'($urandom), TARGET_W'(tgt), COUNT_W'($urandom));
    end else begin
      issue(ACTION_W'($urandom), TARGET_W'($urandom), COUNT_W'($urandom));
    end
  endtask

  // Receiver. It stalls on a pattern of its own: it switches between no stalls, light
  // and heavy random stalls, and a fixed periodic pattern. Once, after enough command
  // beats, it holds off for a long stretch while the sender keeps offering beats; the
  // block then holds one result in its output register, finishes the next command
  // behind it and must stall its input until the hold-off ends.
  initial begin : receiver
    stall_mode_t mode;
    int          mode_left;
    int          tick;
    bit          held;
    mode      = STALL_NONE;
    mode_left = 0;
    tick      = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!held && commands_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
          default:     out_stall <= (tick % 7 < 3);
        endcase
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("flash_block_program_order_tracker_test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset geometry: 256 pages per block, 64 blocks per
    // plane, 4 planes, 1 die, 65536 pages, so blocks 0 to 255 are in range. Seeds only
    // take effect before the first program that passes the range check, so they come
    // first.
    issue(ACT_READ,    TARGET_W'(0),           COUNT_W'(0));    // erased page read
    issue(ACT_PROGRAM, TARGET_W'(65536),       COUNT_W'(0));    // page past the device
    issue(ACT_SEED,    TARGET_W'(5),           COUNT_W'(10));   // still accepted
    issue(ACT_SEED,    TARGET_W'(6),           COUNT_W'(0));    // zero pages: no change
    issue(ACT_SEED,    TARGET_W'(7),           COUNT_W'(257));  // more than a block
    issue(ACT_SEED,    TARGET_W'(8),           COUNT_W'(256));  // exactly a full block
    issue(ACT_SEED,    TARGET_W'(256),         COUNT_W'(1));    // block past the device
    issue(ACT_ERASE,   TARGET_W'(4194303),     COUNT_W'(0));    // largest target
    issue(ACT_READ,    TARGET_W'(5 * 256 + 9), COUNT_W'(0));    // last seeded page
    issue(ACT_READ,    TARGET_W'(5 * 256 + 10), COUNT_W'(0));   // first unwritten page
    issue(ACT_READ,    TARGET_W'(6 * 256),     COUNT_W'(0));    // zero seed left it empty
    issue(ACT_PROGRAM, TARGET_W'(5 * 256 + 10), COUNT_W'(0));   // in order
    issue(ACT_PROGRAM, TARGET_W'(5 * 256 + 12), COUNT_W'(0));   // skips a page
    issue(ACT_SEED,    TARGET_W'(9),           COUNT_W'(3));    // too late now
    issue(ACT_PROGRAM, TARGET_W'(5 * 256),     COUNT_W'(2047)); // page zero restarts
    issue(ACT_READ,    TARGET_W'(5 * 256 + 1), COUNT_W'(0));
    issue(ACT_ERASE,   TARGET_W'(8),           COUNT_W'(0));
    issue(ACT_READ,    TARGET_W'(8 * 256),     COUNT_W'(0));
    issue(ACT_PROGRAM, TARGET_W'(65535),       COUNT_W'(0));    // last page, out of order
    issue(ACT_READ,    TARGET_W'(4194303),     COUNT_W'(0));
    issue(ACT_ERASE,   TARGET_W'(255),         COUNT_W'(0));    // last block in range
    issue(ACT_PROGRAM, TARGET_W'(0),           COUNT_W'(2047));
    drain();

    // Random phases, one per geometry: the smallest, all zero (read as one), a large
    // one, some odd divisors, a page total that leaves the table as the only limit,
    // random register data with stray upper bits, and one bank per block.
    configure(1, 1, 1, 1, 1);
    repeat (60) random_command();
    drain();
    configure(0, 0, 0, 0, 0);
    repeat (60) random_command();
    drain();
    configure(1024, 4096, 16, 4, 4194304);
    repeat (150) random_command();
    drain();
    configure(4, 3, 5, 3, 3000);
    repeat (200) random_command();
    drain();
    configure(8, 7, 2, 2, 4194303);
    repeat (200) random_command();
    drain();
    configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
              CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    repeat (150) random_command();
    drain();
    configure(2, 1, 1, 4, 9000);
    repeat (180) random_command();
    drain();

    if (mismatches == 0) begin
      $display("flash_block_program_order_tracker_test passed");
    end else begin
      $display("flash_block_program_order_tracker_test failed");
    end
    $finish;
  end

endmodule

@@ flash_block_program_order_tracker.f @@
hw/rtl/fbpot_pkg.sv
hw/rtl/fbpot_divider.sv
hw/rtl/flash_block_program_order_tracker.sv
hw/rtl/fbpot_checker.sv
tb/flash_block_program_order_tracker_checker.sv
tb/flash_block_program_order_tracker_test.sv
